// File: rtl/gsm_pkg.sv
// Shared types and constants for the generational slot map.
package gsm_pkg;

  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 32;
  localparam int GEN_BITS   = 16;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_ERASE  = 2'd1,
    FUNC_LOOKUP = 2'd2
  } gsm_func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_FULL  = 2'd2
  } gsm_status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_Q_RD,
    S_META_RD,
    S_INS_WR,
    S_KEY_RD,
    S_KEY_CHK,
    S_VAL,
    S_RESULT
  } gsm_state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  key_index;
    logic [15:0] key_generation;
    logic [31:0] value;
  } gsm_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  handle_index;
    logic [15:0] handle_generation;
    logic [31:0] read_value;
  } gsm_rsp_t;

  typedef struct packed {
    logic clr_wr;
    logic cap_req;
    logic res_full;
    logic res_stale;
    logic q_rd;
    logic meta_rd;
    logic ins_wr;
    logic key_rd;
    logic ers_wr;
    logic look_rd;
    logic val_cap;
    logic out_load;
  } gsm_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [1:0] new_func;
    logic       new_idx_bad;
    logic       free_empty;
    logic       hit;
    logic       is_erase;
    logic       out_free;
  } gsm_sts_t;

endpackage

// File: rtl/gsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gsm_ctrl.sv
// Controller state machine that sequences the slot map operations.
module gsm_ctrl
  import gsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gsm_sts_t sts_i,
  output gsm_cmd_t cmd_o
);

  gsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_req = 1'b1;
          unique case (sts_i.new_func)
            FUNC_INSERT: begin
              if (sts_i.free_empty) begin
                cmd_o.res_full = 1'b1;
                state_d        = S_RESULT;
              end else begin
                state_d = S_Q_RD;
              end
            end
            FUNC_ERASE, FUNC_LOOKUP: begin
              if (sts_i.new_idx_bad) begin
                cmd_o.res_stale = 1'b1;
                state_d         = S_RESULT;
              end else begin
                state_d = S_KEY_RD;
              end
            end
            default: begin
              cmd_o.res_stale = 1'b1;
              state_d         = S_RESULT;
            end
          endcase
        end
      end
      S_Q_RD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = S_META_RD;
      end
      S_META_RD: begin
        cmd_o.meta_rd = 1'b1;
        state_d       = S_INS_WR;
      end
      S_INS_WR: begin
        cmd_o.ins_wr = 1'b1;
        state_d      = S_RESULT;
      end
      S_KEY_RD: begin
        cmd_o.key_rd = 1'b1;
        state_d      = S_KEY_CHK;
      end
      S_KEY_CHK: begin
        priority if (!sts_i.hit) begin
          cmd_o.res_stale = 1'b1;
          state_d         = S_RESULT;
        end else if (sts_i.is_erase) begin
          cmd_o.ers_wr = 1'b1;
          state_d      = S_RESULT;
        end else begin
          cmd_o.look_rd = 1'b1;
          state_d       = S_VAL;
        end
      end
      S_VAL: begin
        cmd_o.val_cap = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/gsm_datapath.sv
// Datapath: slot, dense and free-list memories, counters and result registers.
module gsm_datapath
  import gsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  gsm_req_t in_req_i,
  input  gsm_cmd_t cmd_i,
  output gsm_sts_t sts_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gsm_rsp_t out_rsp_o
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int META_W  = GEN_BITS + 1;
  localparam int DENSE_W = VALUE_BITS + IDX_W;

  gsm_req_t             req_q;
  gsm_rsp_t             res_q, res_d, out_q;
  logic                 out_valid_q;
  logic [IDX_W-1:0]     clr_q, head_q, tail_q, slot_q;
  logic                 tail_wrap_q;
  logic [CNT_W-1:0]     free_cnt_q, live_cnt_q;

  logic [IDX_W-1:0]     key_idx, last_pos, slot_d;
  logic [GEN_BITS-1:0]  key_gen;
  logic                 q_written;

  logic                 meta_we, meta_re, pos_we, dense_we, dense_re;
  logic [IDX_W-1:0]     meta_waddr, meta_raddr, pos_waddr, dense_waddr, dense_raddr;
  logic [META_W-1:0]    meta_wdata, meta_rdata;
  logic [IDX_W-1:0]     pos_wdata, pos_rdata, q_rdata;
  logic [DENSE_W-1:0]   dense_wdata, dense_rdata;

  logic                 meta_live;
  logic [GEN_BITS-1:0]  meta_gen;

  assign key_idx   = IDX_W'(req_q.key_index);
  assign key_gen   = GEN_BITS'(req_q.key_generation);
  assign last_pos  = IDX_W'(live_cnt_q - CNT_W'(1));
  assign q_written = tail_wrap_q || (head_q < tail_q);
  assign slot_d    = q_written ? q_rdata : head_q;
  assign meta_live = meta_rdata[GEN_BITS];
  assign meta_gen  = meta_rdata[GEN_BITS-1:0];

  always_comb begin
    meta_we     = cmd_i.clr_wr || cmd_i.ins_wr || cmd_i.ers_wr;
    meta_waddr  = key_idx;
    meta_wdata  = {1'b0, meta_gen + GEN_BITS'(1)};
    if (cmd_i.clr_wr) begin
      meta_waddr = clr_q;
      meta_wdata = '0;
    end else if (cmd_i.ins_wr) begin
      meta_waddr = slot_q;
      meta_wdata = {1'b1, meta_gen};
    end
    meta_re    = cmd_i.meta_rd || cmd_i.key_rd;
    meta_raddr = cmd_i.meta_rd ? slot_d : key_idx;

    pos_we    = cmd_i.ins_wr || cmd_i.ers_wr;
    pos_waddr = cmd_i.ins_wr ? slot_q : dense_rdata[IDX_W-1:0];
    pos_wdata = cmd_i.ins_wr ? last_pos + IDX_W'(1) - IDX_W'(1) : pos_rdata;
    if (cmd_i.ins_wr) begin
      pos_wdata = IDX_W'(live_cnt_q);
    end

    dense_we    = cmd_i.ins_wr || cmd_i.ers_wr;
    dense_waddr = cmd_i.ins_wr ? IDX_W'(live_cnt_q) : pos_rdata;
    dense_wdata = cmd_i.ins_wr ? {VALUE_BITS'(req_q.value), slot_q} : dense_rdata;
    dense_re    = cmd_i.key_rd || cmd_i.look_rd;
    dense_raddr = cmd_i.key_rd ? last_pos : pos_rdata;
  end

  gsm_ram #(.WIDTH(META_W), .DEPTH(CAPACITY)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  gsm_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .re_i    (cmd_i.key_rd),
    .raddr_i (key_idx),
    .rdata_o (pos_rdata)
  );

  gsm_ram #(.WIDTH(DENSE_W), .DEPTH(CAPACITY)) u_dense_ram (
    .clk_i   (clk_i),
    .we_i    (dense_we),
    .waddr_i (dense_waddr),
    .wdata_i (dense_wdata),
    .re_i    (dense_re),
    .raddr_i (dense_raddr),
    .rdata_o (dense_rdata)
  );

  gsm_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ers_wr),
    .waddr_i (tail_q),
    .wdata_i (key_idx),
    .re_i    (cmd_i.q_rd),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      tail_wrap_q <= 1'b0;
      free_cnt_q  <= CNT_W'(CAPACITY);
      live_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (cmd_i.ins_wr) begin
        head_q     <= (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + IDX_W'(1);
        free_cnt_q <= free_cnt_q - CNT_W'(1);
        live_cnt_q <= live_cnt_q + CNT_W'(1);
      end
      if (cmd_i.ers_wr) begin
        if (tail_q == IDX_W'(CAPACITY - 1)) begin
          tail_q      <= '0;
          tail_wrap_q <= 1'b1;
        end else begin
          tail_q <= tail_q + IDX_W'(1);
        end
        free_cnt_q <= free_cnt_q + CNT_W'(1);
        live_cnt_q <= live_cnt_q - CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.res_full) begin
      res_d        = '0;
      res_d.status = ST_FULL;
    end else if (cmd_i.res_stale) begin
      res_d        = '0;
      res_d.status = ST_STALE;
    end else if (cmd_i.ins_wr) begin
      res_d                   = '0;
      res_d.status            = ST_OK;
      res_d.handle_index      = 10'(slot_q);
      res_d.handle_generation = 16'(meta_gen);
    end else if (cmd_i.ers_wr) begin
      res_d        = '0;
      res_d.status = ST_OK;
    end else if (cmd_i.val_cap) begin
      res_d            = '0;
      res_d.status     = ST_OK;
      res_d.read_value = 32'(dense_rdata[DENSE_W-1:IDX_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_req) begin
      req_q <= in_req_i;
    end
    if (cmd_i.meta_rd) begin
      slot_q <= slot_d;
    end
    res_q <= res_d;
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.clr_done    = (clr_q == IDX_W'(CAPACITY - 1));
    sts_o.new_func    = in_req_i.func;
    sts_o.new_idx_bad = (32'(in_req_i.key_index) >= 32'(CAPACITY));
    sts_o.free_empty  = (free_cnt_q == '0) || (live_cnt_q >= CNT_W'(CAPACITY));
    sts_o.hit         = meta_live && (meta_gen == key_gen);
    sts_o.is_erase    = (req_q.func == FUNC_ERASE);
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: rtl/generational_slot_map_top.sv
// Top level of the generational slot map: controller, datapath and checks.
//
//   Channel  Direction  Handshake                Payload
//   request  in         in_valid_i / in_stall_o  in_req_i   (gsm_req_t)
//   result   out        out_valid_o / out_stall_i out_rsp_o (gsm_rsp_t)
//
// One request is processed at a time; each gives exactly one result.
// States from acceptance to RESULT: insert Q_RD, META_RD, INS_WR; erase
// KEY_RD, KEY_CHK; lookup KEY_RD, KEY_CHK, VAL; a rejected request none.
// After reset the slot generation memory is cleared in state S_CLEAR.
// A stalled result waits in the output register; the next request is
// accepted meanwhile and finishes once the output register frees up.
module generational_slot_map_top
  import gsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gsm_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gsm_rsp_t out_rsp_o
);

  gsm_cmd_t cmd;
  gsm_sts_t sts;

  gsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gsm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while the block stayed idle");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending result");

  a_insert_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_wr |-> !sts.free_empty)
    else $error("insert written with an empty free list");
`endif

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the generational slot map: table-driven and random requests.
module testbench;
  import gsm_pkg::*;

  localparam int CAP = 1024;
  localparam int WATCHDOG = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  gsm_req_t in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  gsm_rsp_t out_rsp_o;

  generational_slot_map_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_rsp_o(out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the slot map.
  logic [9:0]  m_pos [CAP];
  logic [15:0] m_gen [CAP];
  logic        m_live [CAP];
  logic [31:0] m_val [CAP];
  logic [9:0]  m_owner [CAP];
  logic [9:0]  m_freeq [CAP];
  int          m_head, m_tail, m_free, m_used;

  gsm_rsp_t rsp_pending[$];
  int       errors = 0;
  int       idle_cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  // Live handles for building well-formed requests.
  logic [9:0]  h_idx[$];
  logic [15:0] h_gen[$];

  typedef struct {
    gsm_req_t req;
    bit       has_exp;
    gsm_rsp_t exp_rsp;
  } stim_row_t;

  stim_row_t rows[$];

  function automatic gsm_rsp_t map_step(gsm_req_t r);
    gsm_rsp_t o;
    int slot, pos, last, own;
    o = '0;
    o.status = ST_STALE;
    if (r.func == FUNC_INSERT) begin
      if (m_free == 0 || m_used >= CAP) begin
        o.status = ST_FULL;
      end else begin
        slot = m_freeq[m_head];
        pos = m_used;
        m_head = (m_head + 1) % CAP;
        m_free--;
        m_val[pos] = r.value;
        m_owner[pos] = 10'(slot);
        m_pos[slot] = 10'(pos);
        m_live[slot] = 1'b1;
        m_used++;
        o.status = ST_OK;
        o.handle_index = 10'(slot);
        o.handle_generation = m_gen[slot];
      end
    end else if (r.func == FUNC_ERASE) begin
      if (m_live[r.key_index] && m_gen[r.key_index] == r.key_generation && m_used > 0) begin
        pos = m_pos[r.key_index];
        last = m_used - 1;
        own = m_owner[last];
        m_val[pos] = m_val[last];
        m_owner[pos] = 10'(own);
        m_pos[own] = 10'(pos);
        m_live[r.key_index] = 1'b0;
        m_gen[r.key_index] = m_gen[r.key_index] + 16'd1;
        m_freeq[m_tail] = r.key_index;
        m_tail = (m_tail + 1) % CAP;
        m_free++;
        m_used--;
        o.status = ST_OK;
      end
    end else if (r.func == FUNC_LOOKUP) begin
      if (m_live[r.key_index] && m_gen[r.key_index] == r.key_generation) begin
        o.status = ST_OK;
        o.read_value = m_val[m_pos[r.key_index]];
      end
    end
    return o;
  endfunction

  function automatic void track_handles(gsm_req_t r, gsm_rsp_t o);
    if (r.func == FUNC_INSERT && o.status == ST_OK) begin
      h_idx.insert(h_idx.size(), o.handle_index);
      h_gen.insert(h_gen.size(), o.handle_generation);
    end else if (r.func == FUNC_ERASE && o.status == ST_OK) begin
      foreach (h_idx[i]) if (h_idx[i] == r.key_index) begin
        h_idx.delete(i);
        h_gen.delete(i);
        break;
      end
    end
  endfunction

  function automatic void add_row(gsm_req_t req, bit has_exp, gsm_rsp_t exp_rsp);
    stim_row_t row;
    row.req = req;
    row.has_exp = has_exp;
    row.exp_rsp = exp_rsp;
    rows.insert(rows.size(), row);
  endfunction

  task automatic send(gsm_req_t r, bit has_exp, gsm_rsp_t exp_rsp);
    gsm_rsp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    p = map_step(r);
    track_handles(r, p);
    rsp_pending.insert(rsp_pending.size(), has_exp ? exp_rsp : p);
  endtask

  function automatic gsm_req_t mk(logic [1:0] f, logic [9:0] k, logic [15:0] g, logic [31:0] v);
    gsm_req_t r;
    r.func = f; r.key_index = k; r.key_generation = g; r.value = v;
    return r;
  endfunction

  function automatic gsm_rsp_t rs(logic [1:0] s);
    gsm_rsp_t o;
    o = '0;
    o.status = s;
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    gsm_rsp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rsp_pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_rsp_o);
      end else begin
        e = rsp_pending[0];
        rsp_pending.delete(0);
        if (out_rsp_o.status !== e.status || out_rsp_o.handle_index !== e.handle_index ||
            out_rsp_o.handle_generation !== e.handle_generation ||
            out_rsp_o.read_value !== e.read_value) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h actual %h", e, out_rsp_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG + CAP * 2) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic random_phase(int n, int sidle, int rstall);
    gsm_req_t r;
    int sel, k;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) begin
      r = mk(2'($urandom_range(3)), 10'($urandom), 16'($urandom), $urandom);
      sel = $urandom_range(99);
      if (sel < 40) begin
        r.func = FUNC_INSERT;
      end else if (sel < 85 && h_idx.size() > 0) begin
        k = $urandom_range(h_idx.size() - 1);
        r.func = ($urandom_range(1)) ? FUNC_LOOKUP : FUNC_ERASE;
        r.key_index = h_idx[k];
        r.key_generation = h_gen[k];
        if ($urandom_range(9) == 0) r.key_generation = r.key_generation ^ 16'(1 << $urandom_range(15));
      end
      send(r, 1'b0, '0);
    end
  endtask

  initial begin
    int wait_cnt;
    for (int i = 0; i < CAP; i++) begin
      m_pos[i] = '0; m_gen[i] = '0; m_live[i] = 1'b0;
      m_val[i] = '0; m_owner[i] = '0; m_freeq[i] = 10'(i);
    end
    m_head = 0; m_tail = 0; m_free = CAP; m_used = 0;

    add_row(mk(FUNC_LOOKUP, 10'd0, 16'd0, 32'd0), 1'b1, rs(ST_STALE));
    add_row(mk(FUNC_ERASE, 10'd1023, 16'hFFFF, 32'd0), 1'b1, rs(ST_STALE));
    add_row(mk(2'd3, 10'd0, 16'd0, 32'd0), 1'b1, rs(ST_STALE));
    add_row(mk(FUNC_INSERT, 10'd0, 16'd0, 32'hFFFFFFFF), 1'b0, '0);
    add_row(mk(FUNC_INSERT, 10'h3FF, 16'hFFFF, 32'h0), 1'b0, '0);
    add_row(mk(FUNC_INSERT, 10'd0, 16'd0, 32'hA5A55A5A), 1'b0, '0);
    add_row(mk(FUNC_LOOKUP, 10'd0, 16'd0, 32'd0), 1'b0, '0);
    add_row(mk(FUNC_LOOKUP, 10'd1, 16'd0, 32'd0), 1'b0, '0);
    add_row(mk(FUNC_LOOKUP, 10'd0, 16'd1, 32'd0), 1'b1, rs(ST_STALE));
    add_row(mk(FUNC_ERASE, 10'd0, 16'd0, 32'd0), 1'b1, rs(ST_OK));
    add_row(mk(FUNC_LOOKUP, 10'd0, 16'd0, 32'd0), 1'b1, rs(ST_STALE));
    add_row(mk(FUNC_LOOKUP, 10'd2, 16'd0, 32'd0), 1'b0, '0);
    add_row(mk(FUNC_ERASE, 10'd0, 16'd0, 32'd0), 1'b1, rs(ST_STALE));
    add_row(mk(2'd3, 10'h3FF, 16'hFFFF, 32'hFFFFFFFF), 1'b1, rs(ST_STALE));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send(rows[i].req, rows[i].has_exp, rows[i].exp_rsp);

    // Fill the table to full and probe the full case.
    send_idle_pct = 0;
    while (m_free > 0) send(mk(FUNC_INSERT, 10'($urandom), 16'($urandom), $urandom), 1'b0, '0);
    send(mk(FUNC_INSERT, 10'd0, 16'd0, 32'h12345678), 1'b1, rs(ST_FULL));

    // Random traffic on a nearly full table under each idling pattern.
    random_phase(250, 0, 0);
    random_phase(250, 71, 0);
    random_phase(250, 0, 71);
    random_phase(250, 29, 29);
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;

    wait_cnt = 0;
    while (rsp_pending.size() > 0 && wait_cnt < WATCHDOG) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (20) @(posedge clk_i);
    if (errors == 0 && rsp_pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
